// ----- hw/rtl/gnmc_pkg.sv -----
// Shared constants, types and the neighbor count function of the mine counter.
`timescale 1ns / 1ps
package gnmc_pkg;

   localparam int MAX_WIDTH    = 32;
   localparam int MAX_HEIGHT   = 1024;
   localparam int COL_W        = 5;
   localparam int ROW_W        = 10;
   localparam int WIDTH_REG_W  = 6;
   localparam int HEIGHT_REG_W = 11;
   localparam int COUNT_W      = 4;
   localparam int CSR_DATA_W   = 11;
   localparam int LINE_W       = 2;
   localparam int NUM_SLOTS    = 4;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 6'd16;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 11'd16;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_MAX    = 6'd32;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MAX   = 11'd1024;

   typedef enum logic {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic               mine;
      logic [COUNT_W-1:0] count;
   } result_type;

   // bit 2 = left column, bit 1 = center column, bit 0 = right column
   function automatic logic [COUNT_W-1:0] nbr_count(
      input logic [2:0] up,
      input logic [2:0] mid,
      input logic [2:0] down
   );
      logic [COUNT_W-1:0] sum;
      sum = {3'd0, up[2]} + {3'd0, up[1]} + {3'd0, up[0]}
          + {3'd0, mid[2]} + {3'd0, mid[0]}
          + {3'd0, down[2]} + {3'd0, down[1]} + {3'd0, down[0]};
      if (mid[1]) begin
         sum = '0;
      end
      return sum;
   endfunction

endpackage

// ----- hw/rtl/gnmc_req_if.sv -----
// Input channel: one grid cell per transfer.
`timescale 1ns / 1ps
interface gnmc_req_if;
   logic valid;
   logic ready;
   logic cell_mine;

   modport source (output valid, output cell_mine, input ready);
   modport sink   (input valid, input cell_mine, output ready);
endinterface

// ----- hw/rtl/gnmc_rsp_if.sv -----
// Result channel: one reported cell per transfer.
`timescale 1ns / 1ps
interface gnmc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gnmc_pkg::ROW_W-1:0]    out_row;
   logic [gnmc_pkg::COL_W-1:0]    out_col;
   logic                          is_mine;
   logic [gnmc_pkg::COUNT_W-1:0]  neighbor_count;
   logic                          last_of_run;

   modport source (output valid, output out_row, output out_col, output is_mine,
                   output neighbor_count, output last_of_run, input ready);
   modport sink   (input valid, input out_row, input out_col, input is_mine,
                   input neighbor_count, input last_of_run, output ready);
endinterface

// ----- hw/rtl/gnmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gnmc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/grid_neighbor_mine_count.sv -----
// Top level of the streaming grid neighbor mine counter.
//
// Cells enter on req_chan in raster order, one mine bit per transfer. Each
// cell at row r, column c reports the cell one row up and one column left;
// a row-end cell also reports the last cell of the row above, and on the
// last row the current row is reported as well, so one input causes zero to
// four results on rsp_chan, in row-major order, the final one marked by
// last_of_run. A line memory holds the two rows above, one word per column,
// read when a cell is accepted and written back when it leaves the read
// stage. Results pass the read stage, then the output bank. The bank drains
// one result per cycle while rsp_chan is ready and takes the next cell's
// results as its last pending one leaves; ordinary cells sustain one per
// cycle when rsp_chan does not stall. csr_we writes grid_width (index 0)
// or grid_height (index 1) and restarts the grid. Reset restores 16 by 16
// and restarts the grid. When rsp_chan stalls, the pending results hold and
// one further input waits in the read stage before req_chan.ready drops.
`timescale 1ns / 1ps
module grid_neighbor_mine_count (
   input  logic                              clock,
   input  logic                              reset,
   gnmc_req_if.sink                          req_chan,
   gnmc_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  gnmc_pkg::csr_index_type           csr_index,
   input  logic [gnmc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [gnmc_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [gnmc_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [gnmc_pkg::WIDTH_REG_W-1:0]  w_eff;
   logic [gnmc_pkg::HEIGHT_REG_W-1:0] h_eff;
   logic                              restart;

   logic [gnmc_pkg::COL_W-1:0] col_ff, col_in;
   logic [gnmc_pkg::ROW_W-1:0] row_ff, row_in;
   logic                       row_end, last_row;
   logic                       accept;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_mine_ff, s1_row_end_ff, s1_last_row_ff;
   logic [gnmc_pkg::COL_W-1:0] s1_col_ff;
   logic [gnmc_pkg::ROW_W-1:0] s1_row_ff;
   logic                       fwd_ff;
   logic [gnmc_pkg::LINE_W-1:0] fwd_data_ff;
   logic                       s1_move;

   logic [gnmc_pkg::LINE_W-1:0] ram_rdata, line_word, wr_data;
   logic [2:0]                  vcol, h1_ff, h1_in, h2_ff, h2_in;

   gnmc_pkg::result_type       cand [gnmc_pkg::NUM_SLOTS];
   logic [gnmc_pkg::NUM_SLOTS-1:0] emit;
   gnmc_pkg::result_type       slot_ff [gnmc_pkg::NUM_SLOTS];
   logic [gnmc_pkg::NUM_SLOTS-1:0] pend_ff, pend_in, low_bit;
   logic                       buf_free, rsp_xfer;
   gnmc_pkg::result_type       head;

   assign restart = csr_we;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            gnmc_pkg::CSR_GRID_WIDTH:  width_in  = csr_wdata[gnmc_pkg::WIDTH_REG_W-1:0];
            gnmc_pkg::CSR_GRID_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (width_ff == '0) begin
         w_eff = 6'd1;
      end else if (width_ff > gnmc_pkg::WIDTH_MAX) begin
         w_eff = gnmc_pkg::WIDTH_MAX;
      end else begin
         w_eff = width_ff;
      end
      priority if (height_ff == '0) begin
         h_eff = 11'd1;
      end else if (height_ff > gnmc_pkg::HEIGHT_MAX) begin
         h_eff = gnmc_pkg::HEIGHT_MAX;
      end else begin
         h_eff = height_ff;
      end
   end

   assign row_end  = ({1'b0, col_ff} == (w_eff - 6'd1));
   assign last_row = ({1'b0, row_ff} == (h_eff - 11'd1));

   // input side
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 10'd1;
         end else begin
            col_in = col_ff + 5'd1;
         end
      end else begin
         col_in = col_ff;
         row_in = row_ff;
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);

   // line memory: bit 1 = row r-2, bit 0 = row r-1
   gnmc_ram #(
      .WIDTH (gnmc_pkg::LINE_W),
      .DEPTH (gnmc_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      line_word = fwd_ff ? fwd_data_ff : ram_rdata;
      if (s1_row_ff == '0) begin
         line_word = '0;
      end
      vcol    = {line_word, s1_mine_ff};
      wr_data = {line_word[0], s1_mine_ff};
   end

   // candidate results: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
   always_comb begin
      cand[0].row   = s1_row_ff - 10'd1;
      cand[0].col   = s1_col_ff - 5'd1;
      cand[0].mine  = h1_ff[1];
      cand[0].count = gnmc_pkg::nbr_count({h2_ff[2], h1_ff[2], vcol[2]},
                                          {h2_ff[1], h1_ff[1], vcol[1]},
                                          {h2_ff[0], h1_ff[0], vcol[0]});
      cand[1].row   = s1_row_ff - 10'd1;
      cand[1].col   = s1_col_ff;
      cand[1].mine  = vcol[1];
      cand[1].count = gnmc_pkg::nbr_count({h1_ff[2], vcol[2], 1'b0},
                                          {h1_ff[1], vcol[1], 1'b0},
                                          {h1_ff[0], vcol[0], 1'b0});
      cand[2].row   = s1_row_ff;
      cand[2].col   = s1_col_ff - 5'd1;
      cand[2].mine  = h1_ff[0];
      cand[2].count = gnmc_pkg::nbr_count({h2_ff[1], h1_ff[1], vcol[1]},
                                          {h2_ff[0], h1_ff[0], vcol[0]},
                                          3'b000);
      cand[3].row   = s1_row_ff;
      cand[3].col   = s1_col_ff;
      cand[3].mine  = vcol[0];
      cand[3].count = gnmc_pkg::nbr_count({h1_ff[1], vcol[1], 1'b0},
                                          {h1_ff[0], vcol[0], 1'b0},
                                          3'b000);
      emit[0] = (s1_row_ff != '0) && (s1_col_ff != '0);
      emit[1] = (s1_row_ff != '0) && s1_row_end_ff;
      emit[2] = s1_last_row_ff && (s1_col_ff != '0);
      emit[3] = s1_last_row_ff && s1_row_end_ff;
   end

   // output bank
   assign low_bit  = pend_ff & (~pend_ff + 4'd1);
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;
   assign buf_free = (pend_ff == '0) || ((pend_ff == low_bit) && rsp_chan.ready);
   assign s1_move  = s1_valid_ff && ((emit == '0) || buf_free);

   always_comb begin
      pend_in = pend_ff;
      priority if (s1_move && (emit != '0)) begin
         pend_in = emit;
      end else if (rsp_xfer) begin
         pend_in = pend_ff & ~low_bit;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_comb begin
      h1_in = h1_ff;
      h2_in = h2_ff;
      priority if (restart) begin
         h1_in = '0;
         h2_in = '0;
      end else if (s1_move) begin
         if (s1_row_end_ff) begin
            h1_in = '0;
            h2_in = '0;
         end else begin
            h1_in = vcol;
            h2_in = h1_ff;
         end
      end else begin
         h1_in = h1_ff;
         h2_in = h2_ff;
      end
   end

   always_comb begin
      head = slot_ff[0];
      unique case (low_bit)
         4'b0010: head = slot_ff[1];
         4'b0100: head = slot_ff[2];
         4'b1000: head = slot_ff[3];
         default: head = slot_ff[0];
      endcase
   end

   assign rsp_chan.valid          = pend_ff != '0;
   assign rsp_chan.out_row        = head.row;
   assign rsp_chan.out_col        = head.col;
   assign rsp_chan.is_mine        = head.mine;
   assign rsp_chan.neighbor_count = head.count;
   assign rsp_chan.last_of_run    = (pend_ff & ~low_bit) == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= gnmc_pkg::WIDTH_RESET;
         height_ff   <= gnmc_pkg::HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         pend_ff     <= '0;
         h1_ff       <= '0;
         h2_ff       <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         pend_ff     <= pend_in;
         h1_ff       <= h1_in;
         h2_ff       <= h2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mine_ff     <= req_chan.cell_mine;
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_row_end_ff  <= row_end;
         s1_last_row_ff <= last_row;
         fwd_ff         <= s1_move && (s1_col_ff == col_ff);
         fwd_data_ff    <= wr_data;
      end
      if (s1_move && (emit != '0)) begin
         for (int i = 0; i < gnmc_pkg::NUM_SLOTS; i++) begin
            slot_ff[i] <= cand[i];
         end
      end
   end

endmodule
